### design/swra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_pkg: shared types and constants for the sliding-window range area sum
// Sample width, configuration defaults and the control bundle that drives the
// shared compare unit.
// ----------------------------------------------------------------------------
package swra_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int RADIUS_W       = 16;
  localparam int AREA_W         = 64;
  localparam int COUNT_W        = 32;
  localparam int MAX_RADIUS_DEF = 32768;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd22050;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage

### design/swra_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_ring: sample ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swra_ring #(
  parameter int DEPTH = 2 * swra_pkg::MAX_RADIUS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [swra_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [swra_pkg::SAMPLE_W-1:0] rd_data
);

  logic [swra_pkg::SAMPLE_W-1:0] mem_r [DEPTH];
  logic [swra_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/swra_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_scan: shared max/min compare unit
// Tracks the largest and smallest sample of a ring walk with their slots;
// the first hit of an extremum is kept on ties.
// ----------------------------------------------------------------------------
module swra_scan #(
  parameter int AW = 16
) (
  input  logic                          clk,
  input  swra_pkg::scan_ctl_t           ctl,
  input  logic [swra_pkg::SAMPLE_W-1:0] data,
  input  logic [AW-1:0]                 idx,
  output logic [swra_pkg::SAMPLE_W-1:0] hi,
  output logic [AW-1:0]                 hi_pos,
  output logic [swra_pkg::SAMPLE_W-1:0] lo,
  output logic [AW-1:0]                 lo_pos
);

  logic [swra_pkg::SAMPLE_W-1:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [AW-1:0]                 hi_pos_r, hi_pos_nxt, lo_pos_r, lo_pos_nxt;

  always_comb begin
    hi_nxt     = hi_r;
    hi_pos_nxt = hi_pos_r;
    lo_nxt     = lo_r;
    lo_pos_nxt = lo_pos_r;
    if (ctl.vld) begin
      if (ctl.first || (data > hi_r)) begin
        hi_nxt     = data;
        hi_pos_nxt = idx;
      end
      if (ctl.first || (data < lo_r)) begin
        lo_nxt     = data;
        lo_pos_nxt = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r     <= hi_nxt;
    hi_pos_r <= hi_pos_nxt;
    lo_r     <= lo_nxt;
    lo_pos_r <= lo_pos_nxt;
  end

  assign hi     = hi_r;
  assign hi_pos = hi_pos_r;
  assign lo     = lo_r;
  assign lo_pos = lo_pos_r;

endmodule

### design/sliding_window_range_area_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_range_area_sum: running range area over a sample window
// Stores samples in a ring of 2*R slots, sums max-min before each stored
// sample once R are in, rescans the ring when an extremum slot is overwritten,
// runs a mirrored tail pass on the final sample and emits area plus count*2R.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_stall       in_sample, in_last
//   out_     output     out_valid / out_stall     out_area_sum, out_sample_count,
//                                                 out_too_short
//   cfg_     input      cfg_wr_en                 cfg_wr_data (radius)
//
// A plain sample is accepted without leaving idle; one that overwrites an extremum
// slot rescans the D = 2R ring slots, one ring read per cycle into the compare unit.
// A final sample adds the tail pass and the ST_MUL and ST_SUM steps for the product
// and the saturating sum, then waits for the output register to free up.
// Reset is synchronous, active low; radius returns to 22050 and the stream
// state clears. The ring needs no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_range_area_sum #(
  parameter int MAX_RADIUS = swra_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [swra_pkg::RADIUS_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swra_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swra_pkg::AREA_W-1:0]   out_area_sum,
  output logic [swra_pkg::COUNT_W-1:0]  out_sample_count,
  output logic                          out_too_short
);

  localparam int DEPTH = 2 * MAX_RADIUS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = AW + 1;
  localparam int SW    = swra_pkg::SAMPLE_W;
  localparam int CW    = swra_pkg::COUNT_W;
  localparam int AR    = swra_pkg::AREA_W;
  localparam int PW    = CW + DW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_TAIL  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_SHORT = 3'd5;

  logic [swra_pkg::RADIUS_W-1:0] radius_r, radius_nxt;
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] max_r, max_nxt, min_r, min_nxt;
  logic [AW-1:0] max_pos_r, max_pos_nxt, min_pos_r, min_pos_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt, pos_r, pos_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0] seen_r, seen_nxt, terms_r, terms_nxt;
  logic [AR-1:0] acc_r, acc_nxt;
  logic          last_r, last_nxt, resc_max_r, resc_max_nxt, resc_min_r, resc_min_nxt;
  logic [DW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          out_valid_r, out_valid_nxt, out_short_r, out_short_nxt;
  logic [AR-1:0] out_area_r, out_area_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic [DW-1:0] r_eff, d_w;
  logic [AW-1:0] pos_c;
  logic          accept, out_free, rd_en, walk_done, add_en, clr;
  logic          n_ge_r, n_ge_d, hit_max, hit_min;
  logic [CW-1:0] seen_inc;
  logic [SW-1:0] range_c;
  logic [AR:0]   acc_sum, tot_sum;
  logic [SW-1:0] rd_data, hi, lo;
  logic [AW-1:0] hi_pos, lo_pos;
  swra_pkg::scan_ctl_t scan_ctl;

  always_comb begin
    if (radius_r == '0) begin
      r_eff = DW'(1);
    end else if (radius_r > swra_pkg::RADIUS_W'(MAX_RADIUS)) begin
      r_eff = DW'(MAX_RADIUS);
    end else begin
      r_eff = DW'(radius_r);
    end
  end

  assign d_w       = r_eff << 1;
  assign pos_c     = ({1'b0, wpos_r} >= d_w) ? '0 : wpos_r;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign n_ge_r    = (seen_r >= CW'(r_eff));
  assign n_ge_d    = (seen_r >= CW'(d_w));
  assign hit_max   = n_ge_d && (max_pos_r == pos_c);
  assign hit_min   = n_ge_d && (min_pos_r == pos_c);
  assign seen_inc  = (seen_r == '1) ? seen_r : seen_r + 1'b1;
  assign rd_en     = ((state_r == ST_SCAN) || (state_r == ST_TAIL)) && (k_r != d_w);
  assign walk_done = (k_r == d_w) && !rd_vld_r;
  assign range_c   = (state_r == ST_TAIL) ? (hi - lo) : (max_r - min_r);
  assign add_en    = (accept && n_ge_r) ||
                     ((state_r == ST_TAIL) && rd_vld_r && (cnt_r >= r_eff));
  assign acc_sum   = {1'b0, acc_r} + (AR + 1)'(range_c);
  assign tot_sum   = {1'b0, acc_r} + (AR + 1)'(prod_r);

  assign scan_ctl.vld   = rd_vld_r;
  assign scan_ctl.first = (cnt_r == '0);

  swra_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (pos_c),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  swra_scan #(
    .AW (AW)
  ) u_scan (
    .clk    (clk),
    .ctl    (scan_ctl),
    .data   (rd_data),
    .idx    (rd_idx_r),
    .hi     (hi),
    .hi_pos (hi_pos),
    .lo     (lo),
    .lo_pos (lo_pos)
  );

  always_comb begin
    radius_nxt    = radius_r;
    state_nxt     = state_r;
    max_nxt       = max_r;
    max_pos_nxt   = max_pos_r;
    min_nxt       = min_r;
    min_pos_nxt   = min_pos_r;
    wpos_nxt      = wpos_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    seen_nxt      = seen_r;
    terms_nxt     = terms_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    resc_max_nxt  = resc_max_r;
    resc_min_nxt  = resc_min_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_area_nxt  = out_area_r;
    out_count_nxt = out_count_r;
    out_short_nxt = out_short_r;
    clr           = 1'b0;

    if (add_en) begin
      acc_nxt   = acc_sum[AR] ? '1 : acc_sum[AR-1:0];
      terms_nxt = (terms_r == '1) ? terms_r : terms_r + 1'b1;
    end

    if (rd_en) begin
      k_nxt   = k_r + 1'b1;
      ptr_nxt = (ptr_r == '0) ? AW'(d_w - 1'b1) : ptr_r - 1'b1;
    end
    if (rd_vld_r) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!hit_max && (in_sample > max_r)) begin
            max_nxt     = in_sample;
            max_pos_nxt = pos_c;
          end
          if (!hit_min && (in_sample < min_r)) begin
            min_nxt     = in_sample;
            min_pos_nxt = pos_c;
          end
          wpos_nxt     = (DW'(pos_c) + 1'b1 == d_w) ? '0 : pos_c + 1'b1;
          seen_nxt     = seen_inc;
          pos_nxt      = pos_c;
          last_nxt     = in_last;
          resc_max_nxt = hit_max;
          resc_min_nxt = hit_min;
          k_nxt        = '0;
          cnt_nxt      = '0;
          ptr_nxt      = pos_c;
          if (hit_max || hit_min) begin
            state_nxt = ST_SCAN;
          end else if (in_last) begin
            state_nxt = (seen_inc <= CW'(d_w)) ? ST_SHORT : ST_TAIL;
          end
        end
      end
      ST_SCAN: begin
        if (walk_done) begin
          if (resc_max_r) begin
            max_nxt     = hi;
            max_pos_nxt = hi_pos;
          end
          if (resc_min_r) begin
            min_nxt     = lo;
            min_pos_nxt = lo_pos;
          end
          k_nxt   = '0;
          cnt_nxt = '0;
          ptr_nxt = pos_r;
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (seen_r <= CW'(d_w)) begin
            state_nxt = ST_SHORT;
          end else begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (walk_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PW'(terms_r) * PW'(d_w);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = tot_sum[AR] ? '1 : tot_sum[AR-1:0];
          out_count_nxt = terms_r;
          out_short_nxt = 1'b0;
          clr           = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SHORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = '0;
          out_count_nxt = '0;
          out_short_nxt = 1'b1;
          clr           = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      radius_nxt = cfg_wr_data;
      clr        = 1'b1;
    end

    if (clr) begin
      max_nxt     = '0;
      max_pos_nxt = '0;
      min_nxt     = '1;
      min_pos_nxt = '0;
      wpos_nxt    = '0;
      seen_nxt    = '0;
      acc_nxt     = '0;
      terms_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= swra_pkg::RADIUS_RESET;
      state_r     <= ST_IDLE;
      max_r       <= '0;
      max_pos_r   <= '0;
      min_r       <= '1;
      min_pos_r   <= '0;
      wpos_r      <= '0;
      seen_r      <= '0;
      acc_r       <= '0;
      terms_r     <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      radius_r    <= radius_nxt;
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      max_pos_r   <= max_pos_nxt;
      min_r       <= min_nxt;
      min_pos_r   <= min_pos_nxt;
      wpos_r      <= wpos_nxt;
      seen_r      <= seen_nxt;
      acc_r       <= acc_nxt;
      terms_r     <= terms_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    ptr_r       <= ptr_nxt;
    last_r      <= last_nxt;
    resc_max_r  <= resc_max_nxt;
    resc_min_r  <= resc_min_nxt;
    rd_idx_r    <= ptr_r;
    prod_r      <= prod_nxt;
    out_area_r  <= out_area_nxt;
    out_count_r <= out_count_nxt;
    out_short_r <= out_short_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_area_sum     = out_area_r;
  assign out_sample_count = out_count_r;
  assign out_too_short    = out_short_r;

`ifndef SYNTH
  a_wpos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wpos_r} < d_w))
    else $error("write slot beyond window");

  a_extrema_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (seen_r != '0)) |-> (max_r >= min_r))
    else $error("running max below running min");

  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_SUM || $past(state_r) == ST_SHORT))
    else $error("result loaded outside a finish state");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_short_r) |-> ((out_area_r == '0) && (out_count_r == '0)))
    else $error("short stream result carries sums");
`endif

endmodule
